// ===== hdl/btre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btre_pkg
// Shared types and codes of the TFTP boot image receive engine.
// ----------------------------------------------------------------------------
package btre_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_TIMEOUT = 2'd1,
    KIND_HEADER  = 2'd2,
    KIND_BYTE    = 2'd3
  } kind_t;

  // Result actions
  typedef enum logic [1:0] {
    ACT_ANNOUNCE = 2'd0,
    ACT_ACK      = 2'd1,
    ACT_WRITE    = 2'd2
  } action_t;

  // Transfer status carried in results
  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  // Transfer phase
  typedef enum logic [1:0] {
    PH_ANNOUNCE = 2'd0,
    PH_RECEIVE  = 2'd1,
    PH_DONE     = 2'd2
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHECKSUM_ENABLE = 2'd0,
    CFG_MAX_BYTES       = 2'd1,
    CFG_MIN_BYTES       = 2'd2,
    CFG_LOAD_BASE       = 2'd3
  } cfg_index_t;

  localparam int          SIZE_W      = 26;
  localparam int          RETRY_W     = 3;
  localparam int          LEN_W       = 11;
  localparam logic [15:0] OP_WRQ      = 16'd2;
  localparam logic [15:0] OP_DATA     = 16'd3;
  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam logic [2:0]  TIMER_REQ   = 3'd5;
  localparam logic [2:0]  TIMER_RETRY = 3'd2;
  localparam logic [2:0]  TIMER_NONE  = 3'd0;
  localparam logic [10:0] WRQ_MIN_LEN = 11'd6;
  localparam logic [10:0] HDR_LEN     = 11'd4;
  localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = 26'd33554432;

  // One input item
  typedef struct packed {
    kind_t             kind;
    logic [15:0]       dest_port;
    logic [15:0]       src_port;
    logic [15:0]       opcode;
    logic [15:0]       block_number;
    logic [LEN_W-1:0]  packet_len;
    logic              name_terminated;
    logic [7:0]        payload_byte;
  } item_t;

  // One result item
  typedef struct packed {
    action_t           action;
    logic [15:0]       reply_port;
    logic [15:0]       ack_block;
    logic [2:0]        timer_seconds;
    logic [31:0]       write_address;
    logic [7:0]        write_byte;
    status_t           transfer_status;
    logic [SIZE_W-1:0] byte_total;
    logic [31:0]       running_checksum;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic              checksum_enable;
    logic [SIZE_W-1:0] max_bytes;
    logic [SIZE_W-1:0] min_bytes;
    logic [31:0]       load_base;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/bootme_tftp_receive_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bootme_tftp_receive_engine
// TFTP write receiver for boot images: announce with retries, block
// sequencing, size limits, memory writes and an optional running Adler checksum (modulus 65521, halves start at zero).
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction                     Payload
//  s_*      in         start/timeout/header/byte item  tuser kind, tdata fields
//  m_*      out        announce/ack/memory write       tuser action, tdata fields
//  cfg_*    in         register write                  cfg_index, cfg_data
//
//  One item per cycle while the result register is not stalled; a result is offered after its item
//  is accepted and has passed the input register, then the result register.
//  Items that cause no result still pass through the input register.
//  The input side stalls only while the result register is full and not taken.
//  Synchronous reset clears the transfer state and loads register defaults.
// ----------------------------------------------------------------------------
module bootme_tftp_receive_engine
  import btre_pkg::*;
#(
  parameter int BLOCK_BYTES  = 512,
  parameter int MAX_RETRIES  = 4,
  parameter int SERVICE_PORT = 980
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [1:0] kind
  input  wire logic [1:0]   s_tuser,
  // [15:0] dest_port, [31:16] src_port, [47:32] opcode, [63:48] block_number,
  // [74:64] packet_len, [75] name_terminated, [83:76] payload_byte, [87:84] zero
  input  wire logic [87:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [1:0] action
  output logic [1:0]        m_tuser,
  // [15:0] reply_port, [31:16] ack_block, [34:32] timer_seconds,
  // [66:35] write_address, [74:67] write_byte, [76:75] transfer_status,
  // [102:77] byte_total, [134:103] running_checksum, [135] zero
  output logic [135:0]      m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;
  cfg_t    cfg;

  // Unpack the input transaction
  always_comb begin
    in_item.kind            = kind_t'(s_tuser);
    in_item.dest_port       = s_tdata[15:0];
    in_item.src_port        = s_tdata[31:16];
    in_item.opcode          = s_tdata[47:32];
    in_item.block_number    = s_tdata[63:48];
    in_item.packet_len      = s_tdata[74:64];
    in_item.name_terminated = s_tdata[75];
    in_item.payload_byte    = s_tdata[83:76];
  end

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.checksum_enable <= 1'b0;
      cfg.max_bytes       <= MAX_BYTES_RESET;
      cfg.min_bytes       <= '0;
      cfg.load_base       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_CHECKSUM_ENABLE: cfg.checksum_enable <= cfg_data[0];
        CFG_MAX_BYTES:       cfg.max_bytes       <= cfg_data[SIZE_W-1:0];
        CFG_MIN_BYTES:       cfg.min_bytes       <= cfg_data[SIZE_W-1:0];
        CFG_LOAD_BASE:       cfg.load_base       <= cfg_data;
        default:             cfg.load_base       <= cfg.load_base;
      endcase
    end
  end

  // Core takes the held item whenever the result register has room
  assign take = held_valid && out_free;

  btre_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  btre_core #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .MAX_RETRIES  (MAX_RETRIES),
    .SERVICE_PORT (SERVICE_PORT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  btre_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the output transaction
  assign m_tuser = out_res.action;
  assign m_tdata = {1'b0,
                    out_res.running_checksum,
                    out_res.byte_total,
                    out_res.transfer_status,
                    out_res.write_byte,
                    out_res.write_address,
                    out_res.timer_seconds,
                    out_res.ack_block,
                    out_res.reply_port};

endmodule
`default_nettype wire

// ===== hdl/btre_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btre_in_stage
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module btre_in_stage
  import btre_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       held_valid,
  output item_t      held_item
);

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !held_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Capture payload on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/btre_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btre_core
// Transfer state and the single-pass decision logic for one item.
// ----------------------------------------------------------------------------
module btre_core
  import btre_pkg::*;
#(
  parameter int BLOCK_BYTES  = 512,
  parameter int MAX_RETRIES  = 4,
  parameter int SERVICE_PORT = 980
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  take,
  input  wire item_t item,
  output logic       res_valid,
  output result_t    res
);

  // Block offset register width and the width used for end-of-data math
  localparam int OFFS_W = 16 + $clog2(BLOCK_BYTES);
  localparam int EW     = (OFFS_W + 1 > SIZE_W + 1) ? OFFS_W + 1 : SIZE_W + 1;

  phase_t             phase, phase_next;
  logic [RETRY_W-1:0] retry_count, retry_count_next;
  logic [15:0]        last_acked_block, last_acked_block_next;
  logic [LEN_W-1:0]   bytes_pending, bytes_pending_next;
  logic [SIZE_W-1:0]  write_offset, write_offset_next;
  logic [15:0]        adler_low, adler_low_next;
  logic [15:0]        adler_high, adler_high_next;
  // Offset of the next expected block: last_acked_block * BLOCK_BYTES
  logic [OFFS_W-1:0]  block_offset, block_offset_next;

  logic [16:0]        low_sum, high_sum;
  logic [15:0]        low_mod, high_mod;
  logic [LEN_W-1:0]   payload_len;
  logic [EW-1:0]      data_end;
  logic               seq_ok, size_fail;

  // Adler-32 step: one conditional subtract each, sums stay below twice the modulus
  always_comb begin
    low_sum  = {1'b0, adler_low} + {9'd0, item.payload_byte};
    low_mod  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
    high_sum = {1'b0, adler_high} + {1'b0, low_mod};
    high_mod = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
  end

  // Data block checks
  always_comb begin
    payload_len = item.packet_len - HDR_LEN;
    data_end    = EW'(block_offset) + EW'(payload_len);
    seq_ok      = (item.opcode == OP_DATA) && (last_acked_block != 16'hFFFF) &&
                  (item.block_number == 16'(last_acked_block + 16'd1));
    size_fail   = (item.packet_len < HDR_LEN) || (data_end > EW'(cfg.max_bytes));
  end

  // Next state and result
  always_comb begin
    phase_next            = phase;
    retry_count_next      = retry_count;
    last_acked_block_next = last_acked_block;
    bytes_pending_next    = bytes_pending;
    write_offset_next     = write_offset;
    adler_low_next        = adler_low;
    adler_high_next       = adler_high;
    block_offset_next     = block_offset;
    res_valid             = 1'b0;
    res                   = '0;

    case (item.kind)
      KIND_START: begin
        phase_next            = PH_ANNOUNCE;
        retry_count_next      = '0;
        last_acked_block_next = '0;
        bytes_pending_next    = '0;
        write_offset_next     = '0;
        adler_low_next        = '0;
        adler_high_next       = '0;
        block_offset_next     = '0;
        res_valid             = 1'b1;
        res.action            = ACT_ANNOUNCE;
        res.timer_seconds     = TIMER_RETRY;
      end
      KIND_TIMEOUT: begin
        if (phase == PH_ANNOUNCE) begin
          retry_count_next = retry_count + RETRY_W'(1);
          res_valid        = 1'b1;
          res.action       = ACT_ANNOUNCE;
          if (retry_count_next >= RETRY_W'(MAX_RETRIES)) begin
            phase_next          = PH_DONE;
            res.transfer_status = ST_FAIL;
            res.timer_seconds   = TIMER_NONE;
          end else begin
            res.timer_seconds = TIMER_RETRY;
          end
        end else if (phase == PH_RECEIVE) begin
          phase_next          = PH_DONE;
          res_valid           = 1'b1;
          res.action          = ACT_ANNOUNCE;
          res.transfer_status = ST_FAIL;
          res.byte_total      = write_offset;
        end
      end
      KIND_BYTE: begin
        if (bytes_pending != '0) begin
          if (cfg.checksum_enable) begin
            adler_low_next  = low_mod;
            adler_high_next = high_mod;
          end
          write_offset_next  = write_offset + SIZE_W'(1);
          bytes_pending_next = bytes_pending - LEN_W'(1);
          res_valid          = 1'b1;
          res.action         = ACT_WRITE;
          res.write_address  = cfg.load_base + 32'(write_offset);
          res.write_byte     = item.payload_byte;
          res.byte_total     = write_offset_next;
        end
      end
      KIND_HEADER: begin
        if (item.dest_port == 16'(SERVICE_PORT)) begin
          if (phase == PH_ANNOUNCE) begin
            // Accept a usable write request
            if ((item.packet_len >= WRQ_MIN_LEN) && (item.opcode == OP_WRQ) &&
                item.name_terminated) begin
              phase_next            = PH_RECEIVE;
              last_acked_block_next = '0;
              bytes_pending_next    = '0;
              block_offset_next     = '0;
              res_valid             = 1'b1;
              res.action            = ACT_ACK;
              res.reply_port        = item.src_port;
              res.timer_seconds     = TIMER_REQ;
              res.byte_total        = write_offset;
            end
          end else if (phase == PH_RECEIVE) begin
            // Drop any bytes still pending from the previous block
            bytes_pending_next = '0;
            res_valid          = 1'b1;
            res.action         = ACT_ACK;
            res.reply_port     = item.src_port;
            if (seq_ok && size_fail) begin
              phase_next          = PH_DONE;
              res.ack_block       = last_acked_block;
              res.transfer_status = ST_FAIL;
              res.byte_total      = write_offset;
            end else if (seq_ok) begin
              last_acked_block_next = item.block_number;
              write_offset_next     = SIZE_W'(block_offset);
              bytes_pending_next    = payload_len;
              block_offset_next     = block_offset + OFFS_W'(BLOCK_BYTES);
              res.ack_block         = item.block_number;
              res.byte_total        = data_end[SIZE_W-1:0];
              if (payload_len < LEN_W'(BLOCK_BYTES)) begin
                // Short block ends the transfer
                phase_next          = PH_DONE;
                res.transfer_status = (data_end >= EW'(cfg.min_bytes)) ? ST_OK : ST_FAIL;
              end else begin
                res.timer_seconds = TIMER_RETRY;
              end
            end else begin
              // Repeat the last ack
              res.ack_block     = last_acked_block;
              res.timer_seconds = TIMER_RETRY;
              res.byte_total    = write_offset;
            end
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    res.running_checksum = {adler_high_next, adler_low_next};
  end

  // State registers, advance only when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_ANNOUNCE;
      retry_count      <= '0;
      last_acked_block <= '0;
      bytes_pending    <= '0;
      write_offset     <= '0;
      adler_low        <= '0;
      adler_high       <= '0;
      block_offset     <= '0;
    end else if (take) begin
      phase            <= phase_next;
      retry_count      <= retry_count_next;
      last_acked_block <= last_acked_block_next;
      bytes_pending    <= bytes_pending_next;
      write_offset     <= write_offset_next;
      adler_low        <= adler_low_next;
      adler_high       <= adler_high_next;
      block_offset     <= block_offset_next;
    end
  end

`ifndef SYNTHESIS
  // A start item leaves a clean announcing state
  assert property (@(posedge clk) disable iff (rst)
    (take && item.kind == KIND_START) |=>
      (phase == PH_ANNOUNCE && bytes_pending == '0 && write_offset == '0 &&
       retry_count == '0))
    else $error("start did not clear transfer state");

  // Retry counter never passes the limit
  assert property (@(posedge clk) disable iff (rst)
    retry_count <= RETRY_W'(MAX_RETRIES))
    else $error("retry count above limit");

  // Memory writes only come from pending payload bytes
  assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res.action == ACT_WRITE) |-> (bytes_pending != '0))
    else $error("memory write with no bytes pending");

  // A finished transfer ignores timeouts
  assert property (@(posedge clk) disable iff (rst)
    (item.kind == KIND_TIMEOUT && phase == PH_DONE) |-> !res_valid)
    else $error("result from timeout after completion");

  // Adler halves stay reduced
  assert property (@(posedge clk) disable iff (rst)
    (adler_low < 16'(ADLER_MOD)) && (adler_high < 16'(ADLER_MOD)))
    else $error("checksum half not reduced");
`endif

endmodule
`default_nettype wire

// ===== hdl/btre_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btre_out_stage
// Result register: holds one result until the downstream transaction.
// ----------------------------------------------------------------------------
module btre_out_stage
  import btre_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_res,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  // Room when empty or when the held result leaves this cycle
  assign free = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture a new result
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule
`default_nettype wire
